>>> hdl/mpam_pkg.sv
// shared types and constants of the multi-pattern automaton matcher
package mpam_pkg;

    localparam int MAX_NODES = 4096;
    localparam int ALPHABET  = 26;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = NODE_W + 1;
    localparam int LET_W     = 5;
    localparam int CMD_W     = 2;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [LET_W-1:0]  letter_t;
    typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_BUILD  = 2'd2,
        CMD_SCAN   = 2'd3
    } cmd_t;

    localparam cnt_t    NODE_LIMIT  = cnt_t'(MAX_NODES);
    localparam letter_t ALPHA_SIZE  = letter_t'(ALPHABET);
    localparam letter_t LAST_LETTER = letter_t'(ALPHABET - 1);

    // per-node entry: bfs queue slot, end mark, failure link
    typedef struct packed {
        node_t queue;
        logic  mark;
        node_t fail;
    } nent_t;

    // field write enables of a node entry
    typedef struct packed {
        logic queue;
        logic mark;
        logic fail;
    } nwe_t;

endpackage

>>> hdl/mpam_if.sv
// valid/ready channels for command beats and result beats
interface mpam_req_if;
    import mpam_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    letter_t              letter;
    logic                 last_of_pattern;
    logic                 start_of_text;
    modport source (output valid, command, letter, last_of_pattern, start_of_text,
                    input ready);
    modport sink (input valid, command, letter, last_of_pattern, start_of_text,
                  output ready);
endinterface

interface mpam_rsp_if;
    import mpam_pkg::*;
    logic  valid;
    logic  ready;
    node_t node;
    logic  hit;
    logic  status;
    modport source (output valid, node, hit, status, input ready);
    modport sink (input valid, node, hit, status, output ready);
endinterface

>>> hdl/multi_pattern_automaton_matcher_core.sv
// aho-corasick matcher core: trie insert, failure link build, letter scan
// clear and out-of-range letters are answered from idle; insert passes S_INS (and S_INS_NEW
//   when a node is created); scan follows failure links in S_WALK, one goto row read each
// build: S_B_LD loads the root row, S_B_ROOT queues its children, then each node is popped
//   (S_B_POP, S_B_X, S_B_XROW), letters scanned, each child linked and queued; one beat in flight
// reset: cursors and counts cleared, root row reads empty via a valid bit, no clear pass
module multi_pattern_automaton_matcher_core (
    input logic        clk,
    input logic        rst_n,
    mpam_req_if.sink   req,
    mpam_rsp_if.source rsp
);
    import mpam_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_INS     = 13'b0000000000010,
        S_INS_NEW = 13'b0000000000100,
        S_WALK    = 13'b0000000001000,
        S_WALK_MK = 13'b0000000010000,
        S_B_LD    = 13'b0000000100000,
        S_B_ROOT  = 13'b0000001000000,
        S_B_POP   = 13'b0000010000000,
        S_B_X     = 13'b0000100000000,
        S_B_XROW  = 13'b0001000000000,
        S_B_CHILD = 13'b0010000000000,
        S_B_PUSH  = 13'b0100000000000,
        S_B_DONE  = 13'b1000000000000
    } state_t;

    // control state
    state_t state_reg, state_next;
    cnt_t   node_count_reg, node_count_next;
    node_t  ins_cur_reg, ins_cur_next;
    node_t  scan_node_reg, scan_node_next;
    cnt_t   head_reg, head_next;
    cnt_t   tail_reg, tail_next;
    logic   out_valid_reg, out_valid_next;

    // working payload
    letter_t letter_reg, letter_next;
    logic    last_reg, last_next;
    logic    walk_build_reg, walk_build_next;
    node_t   v_reg, v_next;
    cnt_t    steps_reg, steps_next;
    node_t   child_reg, child_next;
    letter_t c_reg, c_next;
    row_t    row_reg, row_next;
    node_t   failx_reg, failx_next;
    node_t   u_reg, u_next;
    node_t   out_node_reg, out_node_next;
    logic    out_hit_reg, out_hit_next;
    logic    out_status_reg, out_status_next;

    // memory ports
    logic  g_clear, g_we;
    node_t g_waddr, g_raddr;
    row_t  g_wdata, g_row;
    nwe_t  n_we;
    node_t n_waddr, n_raddr;
    nent_t n_wdata, n_ent;

    logic    accept;
    logic    produce;
    node_t   p_node;
    logic    p_hit, p_status;
    letter_t walk_letter;
    node_t   walk_child;
    node_t   ins_child;
    node_t   new_node;
    node_t   v_start;

    mpam_goto_ram u_goto (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (g_clear),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_row)
    );

    mpam_node_ram u_node (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (n_wdata),
        .raddr (n_raddr),
        .rdata (n_ent)
    );

    // a new beat only when idle and the result slot is free or draining
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign walk_letter = walk_build_reg ? c_reg : letter_reg;
    assign walk_child  = g_row[walk_letter];
    assign ins_child   = g_row[letter_reg];
    assign new_node    = node_count_reg[NODE_W-1:0];
    assign v_start     = req.start_of_text ? '0 : scan_node_reg;

    always_comb
    begin
        state_next      = state_reg;
        node_count_next = node_count_reg;
        ins_cur_next    = ins_cur_reg;
        scan_node_next  = scan_node_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        letter_next     = letter_reg;
        last_next       = last_reg;
        walk_build_next = walk_build_reg;
        v_next          = v_reg;
        steps_next      = steps_reg;
        child_next      = child_reg;
        c_next          = c_reg;
        row_next        = row_reg;
        failx_next      = failx_reg;
        u_next          = u_reg;
        produce         = 1'b0;
        p_node          = '0;
        p_hit           = 1'b0;
        p_status        = 1'b0;
        g_clear         = 1'b0;
        g_we            = 1'b0;
        g_waddr         = '0;
        g_wdata         = '0;
        g_raddr         = '0;
        n_we            = '0;
        n_waddr         = '0;
        n_wdata         = '0;
        n_raddr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    letter_next = req.letter;
                    last_next   = req.last_of_pattern;
                    unique case (cmd_t'(req.command))
                        CMD_CLEAR:
                        begin
                            g_clear         = 1'b1;
                            node_count_next = cnt_t'(1);
                            ins_cur_next    = '0;
                            scan_node_next  = '0;
                            produce         = 1'b1;
                        end
                        CMD_INSERT:
                        begin
                            if (req.letter >= ALPHA_SIZE)
                            begin
                                produce = 1'b1;
                                p_node  = ins_cur_reg;
                            end
                            else
                            begin
                                g_raddr    = ins_cur_reg;
                                state_next = S_INS;
                            end
                        end
                        CMD_BUILD:
                        begin
                            g_raddr    = '0;
                            head_next  = '0;
                            tail_next  = '0;
                            c_next     = '0;
                            state_next = S_B_LD;
                        end
                        CMD_SCAN:
                        begin
                            if (req.letter >= ALPHA_SIZE)
                            begin
                                scan_node_next = '0;
                                produce        = 1'b1;
                            end
                            else
                            begin
                                g_raddr         = v_start;
                                n_raddr         = v_start;
                                v_next          = v_start;
                                steps_next      = '0;
                                walk_build_next = 1'b0;
                                state_next      = S_WALK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS:
            begin
                if (ins_child == '0)
                begin
                    if (node_count_reg >= NODE_LIMIT)
                    begin
                        // table full: nothing created
                        produce  = 1'b1;
                        p_status = 1'b1;
                        if (last_reg)
                        begin
                            ins_cur_next = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        g_we                  = 1'b1;
                        g_waddr               = ins_cur_reg;
                        g_wdata               = ins_child == '0 ? g_row : g_row;
                        g_wdata[letter_reg]   = new_node;
                        u_next                = new_node;
                        node_count_next       = node_count_reg + cnt_t'(1);
                        state_next            = S_INS_NEW;
                    end
                end
                else
                begin
                    produce = 1'b1;
                    p_node  = ins_child;
                    if (last_reg)
                    begin
                        n_we.mark    = 1'b1;
                        n_waddr      = ins_child;
                        n_wdata.mark = 1'b1;
                        ins_cur_next = '0;
                    end
                    else
                    begin
                        ins_cur_next = ins_child;
                    end
                    state_next = S_IDLE;
                end
            end

            S_INS_NEW:
            begin
                // fresh node: empty row, root link, end mark if pattern ends
                g_we         = 1'b1;
                g_waddr      = u_reg;
                g_wdata      = '0;
                n_we.fail    = 1'b1;
                n_we.mark    = 1'b1;
                n_waddr      = u_reg;
                n_wdata.mark = last_reg;
                produce      = 1'b1;
                p_node       = u_reg;
                ins_cur_next = last_reg ? '0 : u_reg;
                state_next   = S_IDLE;
            end

            S_WALK:
            begin
                // follow failure links until a child on the letter, the root or the step bound
                if (v_reg != '0 && walk_child == '0 && steps_reg < NODE_LIMIT)
                begin
                    v_next     = n_ent.fail;
                    g_raddr    = n_ent.fail;
                    n_raddr    = n_ent.fail;
                    steps_next = steps_reg + cnt_t'(1);
                end
                else
                begin
                    child_next = walk_child;
                    n_raddr    = walk_child;
                    state_next = S_WALK_MK;
                end
            end

            S_WALK_MK:
            begin
                if (!walk_build_reg)
                begin
                    scan_node_next = child_reg;
                    produce        = 1'b1;
                    p_node         = child_reg;
                    p_hit          = (child_reg != '0) && n_ent.mark;
                    state_next     = S_IDLE;
                end
                else
                begin
                    // link the child, inherit the end mark of its link target
                    n_we.fail    = 1'b1;
                    n_we.mark    = (child_reg != '0) && n_ent.mark;
                    n_waddr      = u_reg;
                    n_wdata.fail = child_reg;
                    n_wdata.mark = 1'b1;
                    state_next   = S_B_PUSH;
                end
            end

            S_B_LD:
            begin
                row_next   = g_row;
                state_next = S_B_ROOT;
            end

            S_B_ROOT:
            begin
                if (row_reg[c_reg] != '0 && tail_reg < NODE_LIMIT)
                begin
                    n_we.queue    = 1'b1;
                    n_waddr       = tail_reg[NODE_W-1:0];
                    n_wdata.queue = row_reg[c_reg];
                    tail_next     = tail_reg + cnt_t'(1);
                end
                if (c_reg == LAST_LETTER)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    c_next = c_reg + letter_t'(1);
                end
            end

            S_B_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    n_raddr    = head_reg[NODE_W-1:0];
                    head_next  = head_reg + cnt_t'(1);
                    state_next = S_B_X;
                end
                else
                begin
                    state_next = S_B_DONE;
                end
            end

            S_B_X:
            begin
                g_raddr    = n_ent.queue;
                n_raddr    = n_ent.queue;
                state_next = S_B_XROW;
            end

            S_B_XROW:
            begin
                row_next   = g_row;
                failx_next = n_ent.fail;
                c_next     = '0;
                state_next = S_B_CHILD;
            end

            S_B_CHILD:
            begin
                if (row_reg[c_reg] == '0)
                begin
                    if (c_reg == LAST_LETTER)
                    begin
                        state_next = S_B_POP;
                    end
                    else
                    begin
                        c_next = c_reg + letter_t'(1);
                    end
                end
                else
                begin
                    u_next          = row_reg[c_reg];
                    v_next          = failx_reg;
                    g_raddr         = failx_reg;
                    n_raddr         = failx_reg;
                    steps_next      = '0;
                    walk_build_next = 1'b1;
                    state_next      = S_WALK;
                end
            end

            S_B_PUSH:
            begin
                if (tail_reg < NODE_LIMIT)
                begin
                    n_we.queue    = 1'b1;
                    n_waddr       = tail_reg[NODE_W-1:0];
                    n_wdata.queue = u_reg;
                    tail_next     = tail_reg + cnt_t'(1);
                end
                if (c_reg == LAST_LETTER)
                begin
                    state_next = S_B_POP;
                end
                else
                begin
                    c_next     = c_reg + letter_t'(1);
                    state_next = S_B_CHILD;
                end
            end

            S_B_DONE:
            begin
                produce    = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result slot: filled only when free or draining, since a beat enters only then
    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_node_next   = out_node_reg;
        out_hit_next    = out_hit_reg;
        out_status_next = out_status_reg;
        if (produce)
        begin
            out_valid_next  = 1'b1;
            out_node_next   = p_node;
            out_hit_next    = p_hit;
            out_status_next = p_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= cnt_t'(1);
            ins_cur_reg    <= '0;
            scan_node_reg  <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            ins_cur_reg    <= ins_cur_next;
            scan_node_reg  <= scan_node_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg     <= letter_next;
        last_reg       <= last_next;
        walk_build_reg <= walk_build_next;
        v_reg          <= v_next;
        steps_reg      <= steps_next;
        child_reg      <= child_next;
        c_reg          <= c_next;
        row_reg        <= row_next;
        failx_reg      <= failx_next;
        u_reg          <= u_next;
        out_node_reg   <= out_node_next;
        out_hit_reg    <= out_hit_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.node   = out_node_reg;
    assign rsp.hit    = out_hit_reg;
    assign rsp.status = out_status_reg;

`ifndef ASSERT_OFF
    a_node_count: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg != '0 && node_count_reg <= NODE_LIMIT)
        else $error("node count out of range");

    a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("bfs queue head passed tail");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status |-> rsp.node == '0 && !rsp.hit)
        else $error("refused insert reports a node or hit");

    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE || rsp.valid)
        else $error("accepted beat left no trace");
`endif

endmodule

>>> hdl/mpam_goto_ram.sv
// goto table memory, one row of child pointers per node, root row valid bit
module mpam_goto_ram (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            we,
    input  mpam_pkg::node_t waddr,
    input  mpam_pkg::row_t  wdata,
    input  mpam_pkg::node_t raddr,
    output mpam_pkg::row_t  rdata
);
    import mpam_pkg::*;

    row_t  mem [MAX_NODES];
    row_t  q_reg;
    node_t raddr_reg;
    logic  root_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        q_reg     <= mem[raddr];
        raddr_reg <= raddr;
    end

    // other rows are zeroed when their node is created
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            root_valid_reg <= 1'b0;
        end
        else if (we && waddr == '0)
        begin
            root_valid_reg <= 1'b1;
        end
    end

    assign rdata = (raddr_reg == '0 && !root_valid_reg) ? '0 : q_reg;

endmodule

>>> hdl/mpam_node_ram.sv
// per-node memory: failure link, end mark and bfs queue slot, field writes
module mpam_node_ram (
    input  logic            clk,
    input  mpam_pkg::nwe_t  we,
    input  mpam_pkg::node_t waddr,
    input  mpam_pkg::nent_t wdata,
    input  mpam_pkg::node_t raddr,
    output mpam_pkg::nent_t rdata
);
    import mpam_pkg::*;

    nent_t mem [MAX_NODES];
    nent_t q_reg;

    always_ff @(posedge clk)
    begin
        if (we.fail)
        begin
            mem[waddr].fail <= wdata.fail;
        end
        if (we.mark)
        begin
            mem[waddr].mark <= wdata.mark;
        end
        if (we.queue)
        begin
            mem[waddr].queue <= wdata.queue;
        end
        q_reg <= mem[raddr];
    end

    assign rdata = q_reg;

endmodule
